// ===== src/cdq_pkg.sv =====
// Shared constants, types and pointer helpers for the circular deque.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

    // Storage geometry
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Fixed port widths
    localparam int REQ_W = 3;
    localparam int OUT_W = 32;
    localparam int CFG_W = 7;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_REAR  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REM_FRONT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REM_REAR  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PEEK      = 3'd4;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RESP
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;   // apply the request being accepted
        logic rd;     // read front and rear entries into the output register
    } cmd_t;

    // Step a slot pointer up, wrapping at the capacity
    function automatic logic [ADDR_W-1:0] slot_up(input logic [ADDR_W-1:0] s,
                                                  input logic [CNT_W-1:0]  cap);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(s) + (CNT_W + 1)'(1);
        if (sum >= (CNT_W + 1)'(cap))
            return '0;
        return ADDR_W'(sum);
    endfunction

    // Step a slot pointer down, wrapping to capacity minus one
    function automatic logic [ADDR_W-1:0] slot_down(input logic [ADDR_W-1:0] s,
                                                    input logic [CNT_W-1:0]  cap);
        if (s == '0)
            return ADDR_W'(cap - CNT_W'(1));
        return s - ADDR_W'(1);
    endfunction

    // Clamp a written capacity into 1..DEPTH
    function automatic logic [CNT_W-1:0] clamp_cap(input logic [CFG_W-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        if (wide == 32'd0)
            return CNT_W'(1);
        if (wide > 32'(DEPTH))
            return CNT_W'(DEPTH);
        return CNT_W'(wide);
    endfunction

endpackage

`default_nettype wire

// ===== src/cdq_req_if.sv =====
// Request channel: valid/ready handshake with request code and insert value.
// Depends on cdq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cdq_req_if;
    import cdq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic signed [OUT_W-1:0] insert_value;

    modport source (output valid, output req_type, output insert_value, input ready);
    modport sink   (input valid, input req_type, input insert_value, output ready);
endinterface

`default_nettype wire

// ===== src/cdq_rsp_if.sv =====
// Response channel: valid/ready handshake with status flags and end values.
// Depends on cdq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cdq_rsp_if;
    import cdq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    accepted;
    logic signed [OUT_W-1:0] front_value;
    logic signed [OUT_W-1:0] rear_value;
    logic                    empty_flag;
    logic                    full_flag;

    modport source (output valid, output accepted, output front_value,
                    output rear_value, output empty_flag, output full_flag, input ready);
    modport sink   (input valid, input accepted, input front_value,
                    input rear_value, input empty_flag, input full_flag, output ready);
endinterface

`default_nettype wire

// ===== src/cdq_ctrl.sv =====
// Sequencing FSM for the deque: accept a request, read the ends, hold the response.
// Depends on cdq_pkg (state_t, cmd_t).
`timescale 1ns / 1ps
`default_nettype none

module cdq_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  wire logic         rsp_ready,
    output cdq_pkg::cmd_t     cmd
);
    import cdq_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (req_valid) state_next = ST_READ;
            ST_READ: state_next = ST_RESP;
            ST_RESP: if (rsp_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        req_ready = 1'b0;
        rsp_valid = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.exec  = req_valid;
            end
            ST_READ: cmd.rd = 1'b1;
            ST_RESP: rsp_valid = 1'b1;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/cdq_dp.sv =====
// Deque datapath: ring memory, front/rear pointers, entry count, capacity
// register and the response register. Depends on cdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdq_dp (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire cdq_pkg::cmd_t                    cmd,
    input  wire logic                             cfg_we,
    input  wire logic [cdq_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire logic [cdq_pkg::REQ_W-1:0]        req_type,
    input  wire logic signed [cdq_pkg::OUT_W-1:0] insert_value,
    output logic                                  accepted,
    output logic signed [cdq_pkg::OUT_W-1:0]      front_value,
    output logic signed [cdq_pkg::OUT_W-1:0]      rear_value,
    output logic                                  empty_flag,
    output logic                                  full_flag
);
    import cdq_pkg::*;

    logic [DATA_WIDTH-1:0] ring_mem [DEPTH];

    logic [CNT_W-1:0]  cap_reg;
    logic [ADDR_W-1:0] front_reg, front_next;
    logic [ADDR_W-1:0] rear_reg, rear_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              accepted_reg, accepted_next;
    logic              empty_reg, full_reg;
    logic [DATA_WIDTH-1:0] front_rd_reg, rear_rd_reg;

    logic              is_full, is_empty;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CNT_W-1:0]  cap_new;

    assign is_full  = (count_reg == cap_reg);
    assign is_empty = (count_reg == '0);
    assign cap_new  = clamp_cap(cfg_wdata);

    // Request decode and pointer update
    always_comb
    begin
        front_next    = front_reg;
        rear_next     = rear_reg;
        count_next    = count_reg;
        accepted_next = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = front_reg;
        unique case (req_type)
            REQ_INS_FRONT:
            begin
                if (!is_full)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = front_reg;
                    front_next    = slot_up(front_reg, cap_reg);
                    count_next    = count_reg + CNT_W'(1);
                    accepted_next = 1'b1;
                end
            end
            REQ_INS_REAR:
            begin
                if (!is_full)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = rear_reg;
                    rear_next     = slot_down(rear_reg, cap_reg);
                    count_next    = count_reg + CNT_W'(1);
                    accepted_next = 1'b1;
                end
            end
            REQ_REM_FRONT:
            begin
                if (!is_empty)
                begin
                    front_next    = slot_down(front_reg, cap_reg);
                    count_next    = count_reg - CNT_W'(1);
                    accepted_next = 1'b1;
                end
            end
            REQ_REM_REAR:
            begin
                if (!is_empty)
                begin
                    rear_next     = slot_up(rear_reg, cap_reg);
                    count_next    = count_reg - CNT_W'(1);
                    accepted_next = 1'b1;
                end
            end
            REQ_PEEK: accepted_next = 1'b1;
            default: ;
        endcase
    end

    // Queue state; a capacity write empties the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CNT_W'(DEPTH);
            front_reg <= '0;
            rear_reg  <= ADDR_W'(DEPTH - 1);
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            cap_reg   <= cap_new;
            front_reg <= '0;
            rear_reg  <= ADDR_W'(cap_new - CNT_W'(1));
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            count_reg <= count_next;
        end
    end

    // Response flags, captured with the request
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            accepted_reg <= accepted_next;
            empty_reg    <= (count_next == '0);
            full_reg     <= (count_next == cap_reg);
        end
    end

    // Ring memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
            ring_mem[wr_addr] <= DATA_WIDTH'(insert_value);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            front_rd_reg <= ring_mem[slot_down(front_reg, cap_reg)];
            rear_rd_reg  <= ring_mem[slot_up(rear_reg, cap_reg)];
        end
    end

    // Response payload; an empty queue reports all ones
    assign accepted    = accepted_reg;
    assign empty_flag  = empty_reg;
    assign full_flag   = full_reg;
    assign front_value = empty_reg ? '1 : OUT_W'(front_rd_reg);
    assign rear_value  = empty_reg ? '1 : OUT_W'(rear_rd_reg);

endmodule

`default_nettype wire

// ===== src/circular_deque.sv =====
// Top level of the circular deque: controller FSM plus datapath.
// Depends on cdq_pkg, cdq_req_if, cdq_rsp_if, cdq_ctrl and cdq_dp.
//
//   Channel   Dir   Handshake        Payload
//   req       in    valid/ready      req_type, insert_value
//   rsp       out   valid/ready      accepted, front_value, rear_value, empty_flag, full_flag
//   cfg       in    cfg_we           cfg_wdata (capacity, clamped to 1..DEPTH)
//
// A request is handled in order: the accept cycle updates the pointers and writes the
// ring, the next cycle reads both ends from the ring memory, and the response state then
// presents the response beat. One request is in flight.
// A response beat holds until taken; req.ready stays low meanwhile.
// Reset empties the queue with capacity DEPTH; the ring contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module circular_deque (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    cdq_req_if.sink                        req,
    cdq_rsp_if.source                      rsp,
    input  wire logic                      cfg_we,
    input  wire logic [cdq_pkg::CFG_W-1:0] cfg_wdata
);
    import cdq_pkg::*;

    cmd_t cmd;

    // Sequencer
    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Storage and pointers
    cdq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .req_type     (req.req_type),
        .insert_value (req.insert_value),
        .accepted     (rsp.accepted),
        .front_value  (rsp.front_value),
        .rear_value   (rsp.rear_value),
        .empty_flag   (rsp.empty_flag),
        .full_flag    (rsp.full_flag)
    );

endmodule

`default_nettype wire

// ===== src/cdq_chk.sv =====
// Port-level checks for circular_deque, bound to the top level.
// Depends on cdq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

module cdq_chk (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    input  wire logic                      req_ready,
    input  wire logic                      rsp_valid,
    input  wire logic                      rsp_ready,
    input  wire logic                      accepted,
    input  wire logic [cdq_pkg::OUT_W-1:0] front_value,
    input  wire logic [cdq_pkg::OUT_W-1:0] rear_value,
    input  wire logic                      empty_flag,
    input  wire logic                      full_flag
);
    import cdq_pkg::*;

    // Stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(accepted)
            && $stable(front_value) && $stable(rear_value)
            && $stable(empty_flag) && $stable(full_flag))
        else $error("response beat changed while stalled");

    // One request in flight: no accept right after an accept
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in flight");

    // No new request while a response is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request side ready during response");

    // Empty queue reports all-ones end values
    a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && empty_flag |-> (front_value == '1) && (rear_value == '1))
        else $error("empty queue reported non-sentinel values");

    // Capacity is at least one, so never empty and full at once
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(empty_flag && full_flag))
        else $error("empty and full both set");

endmodule

bind circular_deque cdq_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .accepted    (rsp.accepted),
    .front_value (rsp.front_value),
    .rear_value  (rsp.rear_value),
    .empty_flag  (rsp.empty_flag),
    .full_flag   (rsp.full_flag)
);

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for circular_deque: directed table, then random phases.
// Depends on cdq_pkg, cdq_req_if, cdq_rsp_if and the circular_deque RTL.
`timescale 1ns / 1ps

module tb;
    import cdq_pkg::*;

    // Request codes the block must refuse
    localparam logic [REQ_W-1:0] REQ_UNDEF_LO  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNDEF_MID = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNDEF_HI  = 3'd7;

    localparam logic signed [OUT_W-1:0] EMPTY_VAL = '1;
    localparam logic signed [OUT_W-1:0] VAL_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [OUT_W-1:0] VAL_MIN   = 32'sh8000_0000;

    localparam int HOLD_CYCLES  = 150;
    localparam int PHASES       = 15;
    localparam int PHASE_ITEMS  = 100;
    localparam int MAX_REPORTS  = 100;

    typedef struct packed {
        logic                    accepted;
        logic signed [OUT_W-1:0] front_value;
        logic signed [OUT_W-1:0] rear_value;
        logic                    empty_flag;
        logic                    full_flag;
    } deque_result_t;

    // One row of the directed table: a capacity write or a request
    typedef struct packed {
        bit                      is_cap;
        logic [CFG_W-1:0]        cap_val;
        logic [REQ_W-1:0]        code;
        logic signed [OUT_W-1:0] value;
        bit                      typed;
        deque_result_t           want;
    } script_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    cdq_req_if req_ch ();
    cdq_rsp_if rsp_ch ();

    circular_deque dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the deque
    logic signed [OUT_W-1:0] ring_copy [DEPTH];
    int copy_front = 0;
    int copy_rear  = DEPTH - 1;
    int copy_count = 0;
    int copy_size  = DEPTH;

    deque_result_t expected_ends[$];
    deque_result_t row_want;
    bit            row_typed;
    int            results_seen;
    int            errors;

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int wrap_up(input int s);
        return (s + 1 >= copy_size) ? 0 : s + 1;
    endfunction

    function automatic int wrap_down(input int s);
        return (s == 0) ? copy_size - 1 : s - 1;
    endfunction

    // Apply one request to the shadow deque and return the ends it leaves
    function automatic deque_result_t deque_step(input logic [REQ_W-1:0] code,
                                                 input logic signed [OUT_W-1:0] value);
        deque_result_t r;
        logic          ok;
        ok = 1'b0;
        case (code)
            REQ_INS_FRONT:
                if (copy_count < copy_size)
                begin
                    ring_copy[copy_front] = value;
                    copy_front = wrap_up(copy_front);
                    copy_count++;
                    ok = 1'b1;
                end
            REQ_INS_REAR:
                if (copy_count < copy_size)
                begin
                    ring_copy[copy_rear] = value;
                    copy_rear = wrap_down(copy_rear);
                    copy_count++;
                    ok = 1'b1;
                end
            REQ_REM_FRONT:
                if (copy_count > 0)
                begin
                    copy_front = wrap_down(copy_front);
                    copy_count--;
                    ok = 1'b1;
                end
            REQ_REM_REAR:
                if (copy_count > 0)
                begin
                    copy_rear = wrap_up(copy_rear);
                    copy_count--;
                    ok = 1'b1;
                end
            REQ_PEEK:
                ok = 1'b1;
            default:
                ok = 1'b0;
        endcase
        r.accepted   = ok;
        r.empty_flag = (copy_count == 0);
        r.full_flag  = (copy_count == copy_size);
        if (copy_count == 0)
        begin
            r.front_value = EMPTY_VAL;
            r.rear_value  = EMPTY_VAL;
        end
        else
        begin
            r.front_value = ring_copy[wrap_down(copy_front)];
            r.rear_value  = ring_copy[wrap_up(copy_rear)];
        end
        return r;
    endfunction

    // Monitor: check response beats, predict on request beats, track capacity writes
    always @(posedge clk)
    begin : monitor
        deque_result_t got;
        deque_result_t want;
        deque_result_t calc;
        int            n;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = '{rsp_ch.accepted, rsp_ch.front_value, rsp_ch.rear_value,
                        rsp_ch.empty_flag, rsp_ch.full_flag};
                results_seen++;
                if (expected_ends.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: response beat with nothing expected, actual %h",
                                 $time, got);
                end
                else
                begin
                    want = expected_ends.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            if (got.accepted !== want.accepted)
                                $display("%0t: accepted expected %b actual %b",
                                         $time, want.accepted, got.accepted);
                            if (got.front_value !== want.front_value)
                                $display("%0t: front_value expected %h actual %h",
                                         $time, want.front_value, got.front_value);
                            if (got.rear_value !== want.rear_value)
                                $display("%0t: rear_value expected %h actual %h",
                                         $time, want.rear_value, got.rear_value);
                            if (got.empty_flag !== want.empty_flag)
                                $display("%0t: empty_flag expected %b actual %b",
                                         $time, want.empty_flag, got.empty_flag);
                            if (got.full_flag !== want.full_flag)
                                $display("%0t: full_flag expected %b actual %b",
                                         $time, want.full_flag, got.full_flag);
                        end
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                calc = deque_step(req_ch.req_type, req_ch.insert_value);
                expected_ends.push_back(row_typed ? row_want : calc);
            end
            // capacity write clamps to 1..DEPTH and empties the queue
            if (cfg_we)
            begin
                n = int'(cfg_wdata);
                if (n < 1)
                    n = 1;
                if (n > DEPTH)
                    n = DEPTH;
                copy_size  = n;
                copy_front = 0;
                copy_rear  = n - 1;
                copy_count = 0;
            end
        end
    end

    // Response sink: random stalls, one long hold-off, one stall-free stretch
    initial
    begin : sink
        bit held;
        held = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= 300)
            begin
                held = 1'b1;
                rsp_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (results_seen >= 600 && results_seen < 900)
                rsp_ch.ready = 1'b1;
            else
                rsp_ch.ready = ($urandom_range(99) >= 12);
        end
    end

    // Offer one request beat and return at the edge where it is taken
    task automatic send_req(input logic [REQ_W-1:0] code,
                            input logic signed [OUT_W-1:0] value,
                            input bit typed, input deque_result_t want,
                            input bit may_idle);
        int gap;
        gap = (may_idle && $urandom_range(99) < 12) ? $urandom_range(3, 1) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.req_type     = code;
        req_ch.insert_value = value;
        row_typed           = typed;
        row_want            = want;
        req_ch.valid        = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Drain all outstanding responses, then write the capacity register
    task automatic write_capacity(input logic [CFG_W-1:0] v);
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (expected_ends.size() != 0)
            @(posedge clk);
        repeat (2) @(negedge clk);
        cfg_wdata = v;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic script_row_t req_row(input logic [REQ_W-1:0] code,
                                            input logic signed [OUT_W-1:0] value);
        return '{1'b0, '0, code, value, 1'b0, '0};
    endfunction

    function automatic script_row_t chk_row(input logic [REQ_W-1:0] code,
                                            input logic signed [OUT_W-1:0] value,
                                            input logic acc,
                                            input logic signed [OUT_W-1:0] fv,
                                            input logic signed [OUT_W-1:0] rv,
                                            input logic e, input logic f);
        return '{1'b0, '0, code, value, 1'b1, '{acc, fv, rv, e, f}};
    endfunction

    function automatic script_row_t cap_row(input logic [CFG_W-1:0] v);
        return '{1'b1, v, '0, '0, 1'b0, '0};
    endfunction

    function automatic logic signed [OUT_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return EMPTY_VAL;
            default: return $urandom;
        endcase
    endfunction

    // Mix of requests with a given share of inserts
    function automatic logic [REQ_W-1:0] pick_code(input int ins_pct);
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return REQ_UNDEF_LO + REQ_W'($urandom_range(2));
        if (r < 10)
            return REQ_PEEK;
        if (r < 10 + ins_pct * 90 / 100)
            return $urandom_range(1) ? REQ_INS_FRONT : REQ_INS_REAR;
        return $urandom_range(1) ? REQ_REM_FRONT : REQ_REM_REAR;
    endfunction

    // Stimulus
    initial
    begin : stimulus
        script_row_t      script[$];
        int               ins_mix[5];
        logic [CFG_W-1:0] cap;
        int               item_no;
        int               waited;
        int               r;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_PEEK;
        req_ch.insert_value = '0;
        row_typed           = 1'b0;
        row_want            = '0;
        results_seen        = 0;
        errors              = 0;
        ins_mix             = '{90, 50, 15, 70, 30};
        item_no             = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty refusals, undefined codes, extremes, capacity clamps and wrap
        script = {
            chk_row(REQ_PEEK,      '0,        1'b1, EMPTY_VAL, EMPTY_VAL, 1'b1, 1'b0),
            chk_row(REQ_REM_FRONT, '0,        1'b0, EMPTY_VAL, EMPTY_VAL, 1'b1, 1'b0),
            chk_row(REQ_REM_REAR,  '0,        1'b0, EMPTY_VAL, EMPTY_VAL, 1'b1, 1'b0),
            chk_row(REQ_UNDEF_HI,  VAL_MAX,   1'b0, EMPTY_VAL, EMPTY_VAL, 1'b1, 1'b0),
            chk_row(REQ_INS_FRONT, VAL_MAX,   1'b1, VAL_MAX,   VAL_MAX,   1'b0, 1'b0),
            chk_row(REQ_INS_REAR,  VAL_MIN,   1'b1, VAL_MAX,   VAL_MIN,   1'b0, 1'b0),
            chk_row(REQ_UNDEF_LO,  EMPTY_VAL, 1'b0, VAL_MAX,   VAL_MIN,   1'b0, 1'b0),
            chk_row(REQ_UNDEF_MID, '0,        1'b0, VAL_MAX,   VAL_MIN,   1'b0, 1'b0),
            req_row(REQ_REM_FRONT, '0),
            req_row(REQ_REM_REAR,  '0),
            cap_row(7'd1),
            chk_row(REQ_INS_REAR,  '0,            1'b1, '0, '0, 1'b0, 1'b1),
            chk_row(REQ_INS_FRONT, EMPTY_VAL,     1'b0, '0, '0, 1'b0, 1'b1),
            chk_row(REQ_INS_REAR,  32'shAAAAAAAA, 1'b0, '0, '0, 1'b0, 1'b1),
            req_row(REQ_PEEK,      '0),
            req_row(REQ_REM_REAR,  '0),
            cap_row(7'd0),
            chk_row(REQ_INS_FRONT, 32'sh55555555, 1'b1, 32'sh55555555, 32'sh55555555,
                    1'b0, 1'b1),
            req_row(REQ_REM_FRONT, '0),
            cap_row(7'd127),
            chk_row(REQ_PEEK,      '0, 1'b1, EMPTY_VAL, EMPTY_VAL, 1'b1, 1'b0),
            cap_row(7'd2),
            req_row(REQ_INS_FRONT, 32'sd1),
            req_row(REQ_INS_FRONT, 32'sd2),
            chk_row(REQ_INS_REAR,  32'sd3, 1'b0, 32'sd2, 32'sd1, 1'b0, 1'b1),
            req_row(REQ_REM_REAR,  '0),
            req_row(REQ_INS_REAR,  32'sd4),
            req_row(REQ_REM_FRONT, '0),
            req_row(REQ_REM_FRONT, '0),
            req_row(REQ_REM_FRONT, '0)
        };
        foreach (script[i])
        begin
            if (script[i].is_cap)
                write_capacity(script[i].cap_val);
            else
                send_req(script[i].code, script[i].value, script[i].typed,
                         script[i].want, 1'b1);
        end

        // Random phases, each at its own capacity and insert share
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: cap = 7'd64;
                1: cap = 7'd1;
                2: cap = 7'd127;
                3: cap = 7'd0;
                default:
                begin
                    r = $urandom_range(99);
                    if (r < 70)
                        cap = CFG_W'($urandom_range(8, 1));
                    else if (r < 85)
                        cap = CFG_W'($urandom_range(64, 9));
                    else
                        cap = CFG_W'($urandom_range(127, 65));
                end
            endcase
            write_capacity(cap);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                send_req(pick_code(ins_mix[ph % 5]), pick_value(), 1'b0, '0,
                         !(item_no >= 600 && item_no < 900));
                item_no++;
            end
        end

        @(negedge clk);
        req_ch.valid = 1'b0;

        // Let outstanding responses drain, bounded
        waited = 0;
        while (expected_ends.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);

        if (errors == 0 && expected_ends.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/cdq_pkg.sv
src/cdq_req_if.sv
src/cdq_rsp_if.sv
src/cdq_ctrl.sv
src/cdq_dp.sv
src/circular_deque.sv
src/cdq_chk.sv
test/tb.sv
